@@ sv/file_frame_receiver_assert.svh @@
// ----------------------------------------------------------------------------
// file_frame_receiver_assert.svh
// Assertion macros shared by the file frame receiver RTL.
// ----------------------------------------------------------------------------
`ifndef FILE_FRAME_RECEIVER_ASSERT_SVH
`define FILE_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ffr_pkg.sv @@
// ----------------------------------------------------------------------------
// ffr_pkg
// Types, constants and helpers for the file frame receiver.
// ----------------------------------------------------------------------------
package ffr_pkg;

  localparam int NAME_BYTES = 20;
  localparam int NAME_OFS   = 4;
  localparam int TERM_OFS   = NAME_OFS + NAME_BYTES;
  localparam int HDR_BYTES  = NAME_BYTES + 8;
  localparam int ACK_BYTES  = HDR_BYTES + 4;

  localparam int HDR_IDX_W  = $clog2(HDR_BYTES);
  localparam int ACK_IDX_W  = $clog2(ACK_BYTES);
  localparam int NAME_IDX_W = 5;

  localparam logic [31:0] MAGIC_IN  = 32'h5345_4e44;
  localparam logic [31:0] MAGIC_ACK = 32'h7263_7664;
  localparam logic [7:0]  SEPARATOR = 8'h5c;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_DATA
  } phase_t;

  typedef enum logic [2:0] {
    EV_CONSUMED  = 3'd0,
    EV_HEADER_OK = 3'd1,
    EV_DATA      = 3'd2,
    EV_ACK       = 3'd3,
    EV_LINK_ERR  = 3'd4,
    EV_BAD_NAME  = 3'd5
  } event_kind_t;

  // Byte idx of a big-endian 32-bit magic word.
  function automatic logic [7:0] magic_byte(logic [31:0] word, logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = word[31:24];
      2'd1: b = word[23:16];
      2'd2: b = word[15:8];
      default: b = word[7:0];
    endcase
    return b;
  endfunction

endpackage

@@ sv/file_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// file_frame_receiver
// Framed file receiver: magic hunt, header capture, data pass-through and
// acknowledgement generation.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle while the result side does not
// stall and answers each request with one result in the next cycle, so a byte
// stream flows at full clock rate. The exception is the end of a frame: when a
// header with a zero (or negative) size is accepted, or when the last data byte
// passes, the 32-byte acknowledgement ("rcvd" plus the stored 28-byte header)
// follows that result, one byte per cycle while the result side does not stall,
// from the acknowledgement sequencer reading the header register file, and the
// input is stalled until it is done. The output register decouples the sides: a
// new request is accepted in the same cycle the previous result is taken.
module file_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_link_error,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_kind,
  output logic [7:0]  out_out_byte,
  output logic [31:0] out_file_size,
  output logic [4:0]  out_name_start,
  output logic [4:0]  out_name_length,
  output logic        out_run_last
);
  import ffr_pkg::*;
  `include "file_frame_receiver_assert.svh"

  localparam logic [HDR_IDX_W-1:0] HDR_LAST  = HDR_IDX_W'(HDR_BYTES - 1);
  localparam logic [HDR_IDX_W-1:0] NAME_LO   = HDR_IDX_W'(NAME_OFS);
  localparam logic [HDR_IDX_W-1:0] TERM_IDX  = HDR_IDX_W'(TERM_OFS);
  localparam logic [ACK_IDX_W-1:0] ACK_LAST  = ACK_IDX_W'(ACK_BYTES - 1);
  localparam logic [ACK_IDX_W-1:0] ACK_HDR0  = ACK_IDX_W'(4);

  // Control state.
  phase_t                 phase_r, phase_nxt;
  logic [1:0]             magic_idx_r, magic_idx_nxt;
  logic [HDR_IDX_W-1:0]   hdr_cnt_r, hdr_cnt_nxt;
  logic [30:0]            bytes_left_r, bytes_left_nxt;
  logic [NAME_IDX_W-1:0]  sep_pos_r, sep_pos_nxt;
  logic                   sep_vld_r, sep_vld_nxt;
  logic [NAME_IDX_W-1:0]  zero_pos_r, zero_pos_nxt;
  logic                   zero_vld_r, zero_vld_nxt;
  logic                   ack_busy_r, ack_busy_nxt;
  logic [ACK_IDX_W-1:0]   ack_idx_r, ack_idx_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Result register (payload, no reset).
  logic [2:0]             kind_r, kind_nxt;
  logic [7:0]             byte_r, byte_nxt;
  logic [31:0]            size_r, size_nxt;
  logic [4:0]             start_r, start_nxt;
  logic [4:0]             len_r, len_nxt;
  logic                   last_r, last_nxt;

  // Header register file.
  logic [7:0]             hdr_mem [HDR_BYTES];
  logic                   hdr_we;
  logic [7:0]             hdr_wdata;

  logic                   out_free;
  logic                   accept;
  logic                   ack_load;
  logic [7:0]             ack_byte;
  logic [HDR_IDX_W-1:0]   ack_rd_idx;
  logic [31:0]            hdr_size;
  logic [NAME_IDX_W-1:0]  name_idx;
  logic [NAME_IDX_W-1:0]  name_end;
  logic [NAME_IDX_W-1:0]  name_start;
  logic [NAME_IDX_W-1:0]  name_len;
  logic [7:0]             want_byte;

  // The output register can load when it is empty or being emptied.
  assign out_free = !out_valid_r || !out_stall;
  // Input waits while the acknowledgement is streaming or the result is held.
  assign in_stall = ack_busy_r || !out_free;
  assign accept   = in_valid && !in_stall;
  assign ack_load = ack_busy_r && out_free;

  // Acknowledgement byte: magic first, then the stored header.
  assign ack_rd_idx = HDR_IDX_W'(ack_idx_r - ACK_HDR0);
  always_comb begin
    if (ack_idx_r < ACK_HDR0) begin
      ack_byte = magic_byte(MAGIC_ACK, ack_idx_r[1:0]);
    end else begin
      ack_byte = hdr_mem[ack_rd_idx];
    end
  end

  // Header decode from the stored bytes; meaningful once the header is full.
  assign hdr_size   = {hdr_mem[0], hdr_mem[1], hdr_mem[2], hdr_mem[3]};
  assign name_idx   = NAME_IDX_W'(hdr_cnt_r - NAME_LO);
  assign name_end   = zero_vld_r ? zero_pos_r : NAME_IDX_W'(NAME_BYTES);
  assign name_start = sep_vld_r ? NAME_IDX_W'(sep_pos_r + 1'b1) : '0;
  assign name_len   = (name_end > name_start) ? NAME_IDX_W'(name_end - name_start) : '0;
  assign want_byte  = magic_byte(MAGIC_IN, magic_idx_r);

  always_comb begin
    phase_nxt      = phase_r;
    magic_idx_nxt  = magic_idx_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    bytes_left_nxt = bytes_left_r;
    sep_pos_nxt    = sep_pos_r;
    sep_vld_nxt    = sep_vld_r;
    zero_pos_nxt   = zero_pos_r;
    zero_vld_nxt   = zero_vld_r;
    ack_busy_nxt   = ack_busy_r;
    ack_idx_nxt    = ack_idx_r;
    out_valid_nxt  = out_valid_r;
    kind_nxt       = kind_r;
    byte_nxt       = byte_r;
    size_nxt       = size_r;
    start_nxt      = start_r;
    len_nxt        = len_r;
    last_nxt       = last_r;
    hdr_we         = 1'b0;
    hdr_wdata      = in_rx_byte;

    if (out_free) begin
      out_valid_nxt = 1'b0;
    end

    if (ack_load) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = EV_ACK;
      byte_nxt      = ack_byte;
      size_nxt      = '0;
      start_nxt     = '0;
      len_nxt       = '0;
      last_nxt      = (ack_idx_r == ACK_LAST);
      ack_idx_nxt   = ACK_IDX_W'(ack_idx_r + 1'b1);
      if (ack_idx_r == ACK_LAST) begin
        ack_busy_nxt = 1'b0;
      end
    end else if (accept) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = EV_CONSUMED;
      byte_nxt      = '0;
      size_nxt      = '0;
      start_nxt     = '0;
      len_nxt       = '0;
      last_nxt      = 1'b1;

      if (in_link_error) begin
        kind_nxt      = EV_LINK_ERR;
        phase_nxt     = PH_HUNT;
        magic_idx_nxt = '0;
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            hdr_we = 1'b1;
            // The terminator is stored as zero whatever arrived.
            if (hdr_cnt_r == TERM_IDX) begin
              hdr_wdata = '0;
            end
            if (hdr_cnt_r >= NAME_LO && hdr_cnt_r < TERM_IDX && !zero_vld_r) begin
              if (in_rx_byte == 8'h00) begin
                zero_pos_nxt = name_idx;
                zero_vld_nxt = 1'b1;
              end else if (in_rx_byte == SEPARATOR) begin
                sep_pos_nxt = name_idx;
                sep_vld_nxt = 1'b1;
              end
            end
            hdr_cnt_nxt = HDR_IDX_W'(hdr_cnt_r + 1'b1);
            if (hdr_cnt_r == HDR_LAST) begin
              if (name_len == '0) begin
                kind_nxt      = EV_BAD_NAME;
                phase_nxt     = PH_HUNT;
                magic_idx_nxt = '0;
              end else begin
                kind_nxt       = EV_HEADER_OK;
                size_nxt       = hdr_size;
                start_nxt      = name_start;
                len_nxt        = name_len;
                bytes_left_nxt = hdr_size[31] ? '0 : hdr_size[30:0];
                if (hdr_size[31] || hdr_size[30:0] == '0) begin
                  last_nxt      = 1'b0;
                  ack_busy_nxt  = 1'b1;
                  ack_idx_nxt   = '0;
                  phase_nxt     = PH_HUNT;
                  magic_idx_nxt = '0;
                end else begin
                  phase_nxt = PH_DATA;
                end
              end
            end
          end
          PH_DATA: begin
            kind_nxt       = EV_DATA;
            byte_nxt       = in_rx_byte;
            bytes_left_nxt = bytes_left_r - 1'b1;
            if (bytes_left_r == 31'd1) begin
              last_nxt      = 1'b0;
              ack_busy_nxt  = 1'b1;
              ack_idx_nxt   = '0;
              phase_nxt     = PH_HUNT;
              magic_idx_nxt = '0;
            end
          end
          default: begin
            phase_nxt = PH_HUNT;
            if (in_rx_byte == want_byte) begin
              if (magic_idx_r == 2'd3) begin
                phase_nxt     = PH_HEADER;
                magic_idx_nxt = '0;
                hdr_cnt_nxt   = '0;
                sep_pos_nxt   = '0;
                sep_vld_nxt   = 1'b0;
                zero_pos_nxt  = '0;
                zero_vld_nxt  = 1'b0;
              end else begin
                magic_idx_nxt = magic_idx_r + 1'b1;
              end
            end else begin
              // A stray "S" may itself begin the magic.
              magic_idx_nxt = (in_rx_byte == MAGIC_IN[31:24]) ? 2'd1 : 2'd0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      magic_idx_r  <= '0;
      hdr_cnt_r    <= '0;
      bytes_left_r <= '0;
      sep_pos_r    <= '0;
      sep_vld_r    <= 1'b0;
      zero_pos_r   <= '0;
      zero_vld_r   <= 1'b0;
      ack_busy_r   <= 1'b0;
      ack_idx_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      magic_idx_r  <= magic_idx_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      bytes_left_r <= bytes_left_nxt;
      sep_pos_r    <= sep_pos_nxt;
      sep_vld_r    <= sep_vld_nxt;
      zero_pos_r   <= zero_pos_nxt;
      zero_vld_r   <= zero_vld_nxt;
      ack_busy_r   <= ack_busy_nxt;
      ack_idx_r    <= ack_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    byte_r  <= byte_nxt;
    size_r  <= size_nxt;
    start_r <= start_nxt;
    len_r   <= len_nxt;
    last_r  <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_mem[hdr_cnt_r] <= hdr_wdata;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = kind_r;
  assign out_out_byte    = byte_r;
  assign out_file_size   = size_r;
  assign out_name_start  = start_r;
  assign out_name_length = len_r;
  assign out_run_last    = last_r;

  // No request may enter while the acknowledgement is streaming.
  `FFR_ASSERT_IMP(a_ack_blocks_input, clk, rst_n, ack_busy_r, in_stall, "request accepted during ack")
  // The final acknowledgement byte closes the run.
  `FFR_ASSERT_NXT(a_ack_end_last, clk, rst_n, ack_load && ack_idx_r == ACK_LAST, out_run_last && ~ack_busy_r, "ack end not marked last")
  // Data phase always has bytes outstanding.
  `FFR_ASSERT_IMP(a_data_nonzero, clk, rst_n, phase_r == PH_DATA, bytes_left_r != '0, "data phase with no bytes left")
  // Header capture never runs past the header length.
  `FFR_ASSERT_IMP(a_hdr_bound, clk, rst_n, phase_r == PH_HEADER, hdr_cnt_r <= HDR_LAST, "header count overrun")

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the file frame receiver. Byte requests are driven
// with random gaps while the result side stalls at random. Each accepted
// request runs through a behavioral model of the receiver, and every result
// taken from the block is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffr_pkg::*;

  // One result as the block should present it.
  typedef struct {
    event_kind_t kind;
    logic [7:0]  data;
    logic [31:0] file_size;
    logic [4:0]  name_start;
    logic [4:0]  name_len;
    logic        last;
  } rx_event_t;

  // Frame shapes used by the random part of the stimulus.
  localparam int SH_GOOD        = 0;
  localparam int SH_EMPTY       = 1;
  localparam int SH_NEG_SIZE    = 2;
  localparam int SH_BAD_NAME    = 3;
  localparam int SH_LINK_ERR    = 4;
  localparam int SH_FULL_NAME   = 5;
  localparam int SH_SHORT_MAGIC = 6;
  localparam int SH_NOISE       = 7;
  localparam int NUM_SHAPES     = 8;

  localparam int RANDOM_REQUESTS = 195;
  localparam int QUIET_AFTER     = 150;
  localparam int TAIL_CYCLES     = 40;

  // The class keeps its own copy of the receiver state. Each accepted
  // request appends the results it should cause to expected_events, and
  // each result taken from the block is checked against the oldest one.
  class rx_frame_checker;
    phase_t      phase;
    logic [1:0]  magic_idx;
    int          hdr_count;
    logic [7:0]  hdr [HDR_BYTES];
    logic [30:0] bytes_left;
    logic [4:0]  sep_pos;
    bit          sep_seen;
    logic [4:0]  zero_pos;
    bit          zero_seen;
    rx_event_t   expected_events[$];
    int          errors;
    int          checked;
    int          headers;
    int          bad_names;
    int          link_errs;
    int          data_bytes;
    int          ack_bytes;

    function new();
      go_hunt();
      hdr_count  = 0;
      foreach (hdr[i]) hdr[i] = 8'h00;
      bytes_left = '0;
      sep_pos    = '0;
      sep_seen   = 1'b0;
      zero_pos   = '0;
      zero_seen  = 1'b0;
      errors     = 0;
      checked    = 0;
      headers    = 0;
      bad_names  = 0;
      link_errs  = 0;
      data_bytes = 0;
      ack_bytes  = 0;
    endfunction

    function void go_hunt();
      phase     = PH_HUNT;
      magic_idx = 2'd0;
    endfunction

    function void add(event_kind_t kind, logic [7:0] data = '0,
                      logic [31:0] fsize = '0, logic [4:0] start = '0,
                      logic [4:0] len = '0);
      rx_event_t ev;
      ev.kind       = kind;
      ev.data       = data;
      ev.file_size  = fsize;
      ev.name_start = start;
      ev.name_len   = len;
      ev.last       = 1'b0;
      expected_events.push_back(ev);
    endfunction

    // The acknowledgement: "rcvd" and then the stored header.
    function void add_ack();
      for (int i = 0; i < 4; i++) add(EV_ACK, MAGIC_ACK[31 - 8 * i -: 8]);
      for (int i = 0; i < HDR_BYTES; i++) add(EV_ACK, hdr[i]);
    endfunction

    function void predict_events(logic [7:0] b, logic err);
      rx_event_t   ev;
      logic [7:0]  want;
      logic [31:0] fsize;
      int          k;
      int          name_end;
      int          name_beg;
      int          name_len;
      if (err) begin
        go_hunt();
        add(EV_LINK_ERR);
      end else if (phase == PH_HEADER) begin
        k = hdr_count;
        if (k >= HDR_BYTES) begin
          go_hunt();
          add(EV_CONSUMED);
        end else begin
          hdr[k] = b;
          // Separators only count up to the first zero of the name field.
          if (k >= NAME_OFS && k < TERM_OFS && !zero_seen) begin
            if (b == 8'h00) begin
              zero_pos  = 5'(k - NAME_OFS);
              zero_seen = 1'b1;
            end else if (b == SEPARATOR) begin
              sep_pos  = 5'(k - NAME_OFS);
              sep_seen = 1'b1;
            end
          end
          hdr_count = k + 1;
          if (hdr_count < HDR_BYTES) begin
            add(EV_CONSUMED);
          end else begin
            hdr[TERM_OFS] = 8'h00;
            name_end = zero_seen ? int'(zero_pos) : NAME_BYTES;
            name_beg = sep_seen ? int'(sep_pos) + 1 : 0;
            name_len = (name_end > name_beg) ? name_end - name_beg : 0;
            fsize    = {hdr[0], hdr[1], hdr[2], hdr[3]};
            if (name_len < 1 || name_len > NAME_BYTES) begin
              go_hunt();
              add(EV_BAD_NAME);
            end else begin
              add(EV_HEADER_OK, 8'h00, fsize, 5'(name_beg), 5'(name_len));
              bytes_left = fsize[31] ? '0 : fsize[30:0];
              if (bytes_left == '0) begin
                add_ack();
                go_hunt();
              end else begin
                phase = PH_DATA;
              end
            end
          end
        end
      end else if (phase == PH_DATA) begin
        add(EV_DATA, b);
        bytes_left = bytes_left - 31'd1;
        if (bytes_left == '0) begin
          add_ack();
          go_hunt();
        end
      end else begin
        want  = MAGIC_IN[31 - 8 * magic_idx -: 8];
        phase = PH_HUNT;
        if (b == want) begin
          if (magic_idx == 2'd3) begin
            phase     = PH_HEADER;
            magic_idx = 2'd0;
            hdr_count = 0;
            sep_pos   = '0;
            sep_seen  = 1'b0;
            zero_pos  = '0;
            zero_seen = 1'b0;
          end else begin
            magic_idx = magic_idx + 2'd1;
          end
        end else begin
          // A stray "S" may itself open the magic.
          magic_idx = (b == MAGIC_IN[31:24]) ? 2'd1 : 2'd0;
        end
        add(EV_CONSUMED);
      end
      ev      = expected_events.pop_back();
      ev.last = 1'b1;
      expected_events.push_back(ev);
    endfunction

    task flag_mismatch(string msg);
      $display("tb: mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_event(logic [2:0] kind, logic [7:0] data, logic [31:0] fsize,
                     logic [4:0] start, logic [4:0] len, logic last);
      rx_event_t ev;
      if (expected_events.size() == 0) begin
        flag_mismatch($sformatf("result of kind %0d with nothing expected", kind));
        return;
      end
      ev = expected_events.pop_front();
      checked++;
      if (kind !== ev.kind)
        flag_mismatch($sformatf("event_kind %0d, expected %0d", kind, ev.kind));
      if (data !== ev.data)
        flag_mismatch($sformatf("out_byte %0h, expected %0h", data, ev.data));
      if (fsize !== ev.file_size)
        flag_mismatch($sformatf("file_size %0h, expected %0h", fsize, ev.file_size));
      if (start !== ev.name_start)
        flag_mismatch($sformatf("name_start %0d, expected %0d", start, ev.name_start));
      if (len !== ev.name_len)
        flag_mismatch($sformatf("name_length %0d, expected %0d", len, ev.name_len));
      if (last !== ev.last)
        flag_mismatch($sformatf("run_last %0b, expected %0b", last, ev.last));
      case (ev.kind)
        EV_HEADER_OK: headers++;
        EV_BAD_NAME:  bad_names++;
        EV_LINK_ERR:  link_errs++;
        EV_DATA:      data_bytes++;
        EV_ACK:       ack_bytes++;
        default:      ;
      endcase
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        in_link_error;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_event_kind;
  logic [7:0]  out_out_byte;
  logic [31:0] out_file_size;
  logic [4:0]  out_name_start;
  logic [4:0]  out_name_length;
  logic        out_run_last;

  rx_frame_checker frames;
  bit              quiet;     // set for the final stretch: no gaps, no stalls
  int              requests;

  file_frame_receiver dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .in_link_error  (in_link_error),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_kind (out_event_kind),
    .out_out_byte   (out_out_byte),
    .out_file_size  (out_file_size),
    .out_name_start (out_name_start),
    .out_name_length(out_name_length),
    .out_run_last   (out_run_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drives one request and returns once the block has taken it. Inputs move
  // on the falling edge; in_stall is read at the rising edge, where the
  // block's own updates of that edge are not yet visible, so acceptance is
  // judged on the values that held before the edge. An optional gap, with
  // in_valid low, comes first.
  task automatic send_request(logic [7:0] b, logic err);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_rx_byte    <= b;
    in_link_error <= err;
    do @(posedge clk); while (in_stall);
    frames.predict_events(b, err);
    requests++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
  endtask

  // Sends one frame of the given shape. Well-formed frames carry the magic,
  // a 28-byte header and the data; the other shapes break the sequence at
  // some point or are plain noise.
  task automatic send_frame(int shape);
    logic [7:0]  hdr [HDR_BYTES];
    logic [7:0]  b;
    logic [31:0] fsize;
    int          n_data;
    int          total;
    int          cut;
    int          zpos;
    int          variant;
    string       magic_s;
    if (shape == SH_NOISE) begin
      repeat ($urandom_range(1, 6))
        send_request(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      return;
    end
    if (shape == SH_SHORT_MAGIC) begin
      magic_s = "SEND";
      send_text(magic_s.substr(0, $urandom_range(0, 2)));
      send_request(8'($urandom_range(0, 255)), 1'b0);
      return;
    end

    case (shape)
      SH_EMPTY:    fsize = 32'd0;
      SH_NEG_SIZE: fsize = $urandom() | 32'h8000_0000;
      default:     fsize = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40)
                                                       : $urandom_range(1, 12);
    endcase
    {hdr[0], hdr[1], hdr[2], hdr[3]} = fsize;

    // Name bytes are never zero at first; a separator now and then.
    for (int i = 0; i < NAME_BYTES; i++)
      hdr[NAME_OFS + i] = ($urandom_range(0, 7) == 0) ? SEPARATOR
                                                      : 8'($urandom_range(1, 255));
    case (shape)
      SH_FULL_NAME: begin
        // All 20 bytes used, ending on a plain character.
        hdr[TERM_OFS - 1] = 8'($urandom_range(8'h41, 8'h5a));
      end
      SH_BAD_NAME: begin
        variant = $urandom_range(0, 2);
        if (variant == 0) begin
          hdr[NAME_OFS] = 8'h00;
        end else if (variant == 1) begin
          zpos = $urandom_range(1, NAME_BYTES - 1);
          hdr[NAME_OFS + zpos]     = 8'h00;
          hdr[NAME_OFS + zpos - 1] = SEPARATOR;
        end else begin
          hdr[TERM_OFS - 1] = SEPARATOR;
        end
      end
      default: begin
        // Position NAME_BYTES means the name runs to the end of the field.
        zpos = $urandom_range(1, NAME_BYTES);
        if (zpos < NAME_BYTES) hdr[NAME_OFS + zpos] = 8'h00;
      end
    endcase
    for (int i = TERM_OFS; i < HDR_BYTES; i++) hdr[i] = 8'($urandom_range(0, 255));

    n_data = fsize[31] ? 0 : int'(fsize);
    total  = 4 + HDR_BYTES + n_data;
    cut    = (shape == SH_LINK_ERR) ? $urandom_range(0, total - 1) : -1;
    for (int pos = 0; pos < total; pos++) begin
      if (pos == cut) begin
        send_request(8'($urandom_range(0, 255)), 1'b1);
        return;
      end
      if (pos < 4)
        b = MAGIC_IN[31 - 8 * pos -: 8];
      else if (pos < 4 + HDR_BYTES)
        b = hdr[pos - 4];
      else
        b = 8'($urandom_range(0, 255));
      send_request(b, 1'b0);
    end
  endtask

  // Result side: stall in random bursts, never in the quiet stretch at the
  // end.
  initial begin : result_stall
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 9);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // A result is taken at a rising edge with out_valid high and out_stall low.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      frames.check_event(out_event_kind, out_out_byte, out_file_size,
                         out_name_start, out_name_length, out_run_last);
  end

  initial begin : stimulus
    int frame_no;
    int random_start;
    int shape;
    in_valid      = 1'b0;
    in_rx_byte    = 8'h00;
    in_link_error = 1'b0;
    rst_n         = 1'b0;
    quiet         = 1'b0;
    requests      = 0;
    frames        = new();
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed opening: byte extremes, a second "S" that restarts the hunt,
    // a mismatch that falls back to the first magic byte, a link error while
    // hunting and one while a header is being collected.
    send_request(8'h00, 1'b0);
    send_request(8'hff, 1'b0);
    send_text("SSENX");
    send_text("SESEN");
    send_request(8'hff, 1'b1);
    send_text("SEND");
    send_request(8'h53, 1'b0);
    send_request(SEPARATOR, 1'b0);
    send_request(8'h00, 1'b1);
    send_text("END");

    // Random part. The first frames walk through every shape once so each
    // special case is reached; after that most frames are well formed.
    random_start = requests;
    frame_no     = 0;
    while (requests - random_start < RANDOM_REQUESTS) begin
      if (frame_no < NUM_SHAPES)
        shape = frame_no;
      else
        shape = ($urandom_range(0, 9) < 5) ? SH_GOOD : $urandom_range(1, NUM_SHAPES - 1);
      send_frame(shape);
      frame_no++;
      // Once in the run the sender holds off until the block has delivered
      // everything it owes. The last request is withdrawn first so that it
      // is not taken a second time while the sender waits.
      if (frame_no == 3) begin
        @(negedge clk) in_valid <= 1'b0;
        while (frames.expected_events.size() != 0) @(negedge clk);
      end
      if (requests - random_start >= QUIET_AFTER) quiet = 1'b1;
    end
    @(negedge clk) in_valid <= 1'b0;

    // Let the last results drain, then watch a while for stray ones.
    while (frames.expected_events.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("tb: %0d byte requests driven in %0d frames, %0d results checked",
             requests, frame_no, frames.checked);
    $display("tb: %0d headers, %0d bad names, %0d link errors, %0d data, %0d ack bytes",
             frames.headers, frames.bad_names, frames.link_errs, frames.data_bytes,
             frames.ack_bytes);
    if (frames.errors == 0)
      $display("** file_frame_receiver: PASSED **");
    else
      $display("** file_frame_receiver: FAILED **");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of this stimulus.
  initial begin : watchdog
    #(5_000_000);
    $display("tb: timeout, %0d results still expected", frames.expected_events.size());
    $display("** file_frame_receiver: FAILED **");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/ffr_pkg.sv
sv/file_frame_receiver.sv
bench/tb.sv
